@@ src/xor_keyed_ami_line_encoder_macros.svh @@
// Assertion macros for the keyed AMI line encoder.
// No dependencies; included by modules that carry concurrent checks.
`ifndef XOR_KEYED_AMI_LINE_ENCODER_MACROS_SVH
`define XOR_KEYED_AMI_LINE_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define XKA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define XKA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/xka_pkg.sv @@
// Shared types and constants for the keyed AMI line encoder.
// No dependencies; used by xor_keyed_ami_line_encoder.
package xka_pkg;

  localparam int KEY_MAX_BYTES = 16;
  localparam int KEY_POS_W     = 4;
  localparam int KEY_LEN_W     = 5;
  localparam int KEY_WORDS     = 4;
  localparam int SYM_PER_BYTE  = 8;
  localparam int SYM_CNT_W     = 3;

  localparam logic [SYM_CNT_W-1:0] SYM_LAST = SYM_CNT_W'(SYM_PER_BYTE - 1);

  // Register indexes on the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

  // Default key after reset
  localparam logic [31:0] KEY_WORD0_RST = 32'h7361_7242;
  localparam logic [31:0] KEY_WORD1_RST = 32'h6548_6C69;
  localparam logic [31:0] KEY_WORD2_RST = 32'h0000_6178;
  localparam logic [31:0] KEY_WORD3_RST = 32'h0000_0000;
  localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RST = 5'd10;

  // Line levels
  localparam logic signed [1:0] LEVEL_POS  = 2'sb01;
  localparam logic signed [1:0] LEVEL_ZERO = 2'sb00;
  localparam logic signed [1:0] LEVEL_NEG  = 2'sb11;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
    logic       message_end;
  } byte_beat_t;

  typedef struct packed {
    logic signed [1:0] level;
    logic              byte_done;
    logic              message_done;
  } sym_beat_t;

  // Clamp the programmed key length to 1..KEY_MAX_BYTES
  function automatic logic [KEY_LEN_W-1:0] eff_len(input logic [KEY_LEN_W-1:0] len);
    logic [KEY_LEN_W-1:0] n;
    n = len;
    if (n == '0) begin
      n = KEY_LEN_W'(1);
    end
    if (n > KEY_LEN_W'(KEY_MAX_BYTES)) begin
      n = KEY_LEN_W'(KEY_MAX_BYTES);
    end
    return n;
  endfunction

endpackage

@@ src/xor_keyed_ami_line_encoder.sv @@
// Keyed AMI (pseudo-ternary) line encoder: top level.
// Depends on xka_pkg and xor_keyed_ami_line_encoder_macros.svh.
//
//   Channel   Handshake                 Payload            Beat
//   byte      byte_valid / byte_ready   byte_data          one message byte
//   sym       sym_valid / sym_ready     sym_data           one line symbol
//   cfg       cfg_we                    cfg_index/wdata    one register write
//
// Each byte beat yields eight symbol beats, one per cycle while sym_ready is
// high, and the shifter takes the next held byte as the eighth one leaves.
// A byte is enciphered on acceptance and parked in a one-entry holding
// register, so the next byte is taken while the current one is still shifting.
// A byte passes through the holding register and then the shifter before its
// first symbol is offered.
// Reset (rst, synchronous) restores the default key, clears key position and
// polarity, and empties both stages. Stalls on sym hold the shifter in place.
`include "xor_keyed_ami_line_encoder_macros.svh"

module xor_keyed_ami_line_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                byte_valid,
  output logic                                byte_ready,
  input  xka_pkg::byte_beat_t                 byte_data,
  output logic                                sym_valid,
  input  logic                                sym_ready,
  output xka_pkg::sym_beat_t                  sym_data,
  input  logic                                cfg_we,
  input  logic [xka_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_wdata
);

  // Configuration registers
  logic [xka_pkg::KEY_WORDS-1:0][31:0] key_words;
  logic [xka_pkg::KEY_LEN_W-1:0]       key_length;

  // Cipher stage state
  logic [xka_pkg::KEY_POS_W-1:0] key_pos;
  logic [xka_pkg::KEY_POS_W-1:0] key_pos_next;

  // Holding register between cipher and shifter
  logic       hold_valid;
  logic [7:0] hold_enc;
  logic       hold_start;
  logic       hold_last;

  // Symbol shifter
  logic                          ser_valid;
  logic [7:0]                    ser_bits;
  logic [xka_pkg::SYM_CNT_W-1:0] ser_cnt;
  logic                          ser_last;
  logic                          pol;
  logic                          pol_next;

  logic                          byte_fire;
  logic                          sym_fire;
  logic                          ser_final;
  logic                          ser_load;
  logic                          pol_cur;
  logic [xka_pkg::KEY_LEN_W-1:0] len_eff;
  logic [xka_pkg::KEY_POS_W-1:0] pos_use;
  logic [xka_pkg::KEY_LEN_W-1:0] pos_inc;
  logic [7:0]                    key_byte;
  logic [7:0]                    enc_byte;

  // ---------------------------------------------------------------------------
  // Configuration writes; unknown indexes are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      key_words[0] <= xka_pkg::KEY_WORD0_RST;
      key_words[1] <= xka_pkg::KEY_WORD1_RST;
      key_words[2] <= xka_pkg::KEY_WORD2_RST;
      key_words[3] <= xka_pkg::KEY_WORD3_RST;
      key_length   <= xka_pkg::KEY_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xka_pkg::CFG_KEY_WORD0:  key_words[0] <= cfg_wdata;
        xka_pkg::CFG_KEY_WORD1:  key_words[1] <= cfg_wdata;
        xka_pkg::CFG_KEY_WORD2:  key_words[2] <= cfg_wdata;
        xka_pkg::CFG_KEY_WORD3:  key_words[3] <= cfg_wdata;
        xka_pkg::CFG_KEY_LENGTH: key_length   <= cfg_wdata[xka_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign sym_fire  = sym_valid && sym_ready;
  assign ser_final = (ser_cnt == xka_pkg::SYM_LAST);
  // Load the held byte into the shifter when it is empty or its eighth symbol leaves this cycle
  assign ser_load   = hold_valid && (!ser_valid || (sym_fire && ser_final));
  assign byte_ready = !hold_valid || ser_load;
  assign byte_fire  = byte_valid && byte_ready;

  // ---------------------------------------------------------------------------
  // Cipher: pick the key byte, XOR, advance the key position
  // ---------------------------------------------------------------------------
  always_comb begin
    len_eff = xka_pkg::eff_len(key_length);
    // Message start restarts the key; a stale position past the length uses 0
    pos_use = byte_data.message_start ? '0 : key_pos;
    if ({1'b0, pos_use} >= len_eff) begin
      pos_use = '0;
    end
    key_byte = key_words[pos_use[3:2]][{pos_use[1:0], 3'b000} +: 8];
    enc_byte = byte_data.data_byte ^ key_byte;
    pos_inc  = {1'b0, pos_use} + xka_pkg::KEY_LEN_W'(1);
    if (byte_data.message_end || (pos_inc >= len_eff)) begin
      key_pos_next = '0;
    end else begin
      key_pos_next = pos_inc[xka_pkg::KEY_POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_pos <= '0;
    end else if (byte_fire) begin
      key_pos <= key_pos_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Holding register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_fire) begin
      hold_valid <= 1'b1;
    end else if (ser_load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire) begin
      hold_enc   <= enc_byte;
      hold_start <= byte_data.message_start;
      hold_last  <= byte_data.message_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Symbol shifter and mark polarity
  // ---------------------------------------------------------------------------
  always_comb begin
    pol_cur = pol;
    if (sym_fire) begin
      if (ser_final && ser_last) begin
        pol_cur = 1'b0;              // message over: next mark is +1
      end else begin
        pol_cur = pol ^ ~ser_bits[7]; // a mark flips polarity
      end
    end
    pol_next = (ser_load && hold_start) ? 1'b0 : pol_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_cnt   <= '0;
      pol       <= 1'b0;
    end else begin
      pol <= pol_next;
      if (ser_load) begin
        ser_valid <= 1'b1;
        ser_cnt   <= '0;
      end else if (sym_fire) begin
        ser_valid <= !ser_final;
        ser_cnt   <= ser_cnt + xka_pkg::SYM_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_bits <= hold_enc;
      ser_last <= hold_last;
    end else if (sym_fire) begin
      ser_bits <= {ser_bits[6:0], 1'b0};
    end
  end

  // ---------------------------------------------------------------------------
  // Symbol beat: MSB of the shifter, 1 gives zero level, 0 gives a mark
  // ---------------------------------------------------------------------------
  assign sym_valid = ser_valid;

  always_comb begin
    if (ser_bits[7]) begin
      sym_data.level = xka_pkg::LEVEL_ZERO;
    end else if (pol) begin
      sym_data.level = xka_pkg::LEVEL_NEG;
    end else begin
      sym_data.level = xka_pkg::LEVEL_POS;
    end
    sym_data.byte_done    = ser_final;
    sym_data.message_done = ser_final && ser_last;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `XKA_ASSERT_NOW(a_msg_done_on_byte_end, sym_valid && sym_data.message_done,
    sym_data.byte_done, "message_done without byte_done")
  `XKA_ASSERT_NOW(a_ready_low_means_held, !byte_ready, hold_valid,
    "byte_ready low with empty holding register")
  `XKA_ASSERT_NEXT(a_stall_holds_count, sym_valid && !sym_ready,
    sym_valid && $stable(ser_cnt) && $stable(ser_bits), "shifter moved during stall")
  `XKA_ASSERT_NEXT(a_msg_end_clears_pol, sym_fire && sym_data.message_done,
    !pol, "polarity not restored after message end")
  `XKA_ASSERT_NEXT(a_msg_end_clears_key, byte_fire && byte_data.message_end,
    key_pos == '0, "key position not restored after message end")

endmodule

@@ tb/sv/xor_keyed_ami_line_encoder_test.sv @@
// Self-checking testbench for the keyed AMI line encoder: directed and random byte beats,
// a predictor of the eight symbols per byte, and a symbol checker.
// Depends on xka_pkg and the xor_keyed_ami_line_encoder top level.
`timescale 1ns / 1ps

module xor_keyed_ami_line_encoder_test;

  localparam int CYCLE_LIMIT = 100000;  // bound for the watchdog below
  localparam int HOLD_CYCLES = 64;      // long receiver hold-off, enough to stall the byte side
  localparam int TAIL_CYCLES = 16;      // quiet time after the last symbol to catch strays
  localparam logic [xka_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_ready;
  xka_pkg::byte_beat_t  byte_data = '0;
  logic                 sym_valid;
  logic                 sym_ready = 1'b0;
  xka_pkg::sym_beat_t   sym_data;
  logic                 cfg_we = 1'b0;
  logic [xka_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  // Stimulus not yet offered, and symbols predicted but not yet seen
  xka_pkg::byte_beat_t byte_backlog[$];
  xka_pkg::sym_beat_t  symbols_due[$];

  // Predictor copy of the key registers and the encoder state
  logic [31:0]                   key_words [xka_pkg::KEY_WORDS];
  logic [xka_pkg::KEY_LEN_W-1:0] key_len_reg;
  logic [xka_pkg::KEY_POS_W-1:0] key_pos;
  logic                          mark_neg;   // 1: next mark goes out as -1

  int send_idle = 0;       // percent of cycles the sender withholds a beat
  int recv_idle = 0;       // percent of cycles the receiver drops ready
  int hold_requests = 0;   // bumped by the sequence to ask for a long hold-off
  int holds_served = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  xor_keyed_ami_line_encoder DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .sym_valid  (sym_valid),
    .sym_ready  (sym_ready),
    .sym_data   (sym_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Encipher one accepted byte and queue its eight line symbols, MSB first.
  function automatic void encode_byte(input xka_pkg::byte_beat_t b);
    int unsigned        span;
    int unsigned        slot;
    logic [7:0]         cipher;
    xka_pkg::sym_beat_t s;
    // Clamp the programmed length into 1..KEY_MAX_BYTES
    span = 32'(key_len_reg);
    if (span == 0) begin
      span = 1;
    end
    if (span > xka_pkg::KEY_MAX_BYTES) begin
      span = xka_pkg::KEY_MAX_BYTES;
    end
    if (b.message_start) begin
      key_pos  = '0;
      mark_neg = 1'b0;
    end
    // A position left beyond a shortened key falls back to slot 0
    slot = 32'(key_pos);
    if (slot >= span) begin
      slot = 0;
    end
    cipher  = b.data_byte ^ key_words[slot / 4][(slot % 4) * 8 +: 8];
    key_pos = (slot + 1 >= span) ? '0 : xka_pkg::KEY_POS_W'(slot + 1);
    for (int k = 7; k >= 0; k--) begin
      if (cipher[k]) begin
        s.level = xka_pkg::LEVEL_ZERO;
      end else begin
        s.level  = mark_neg ? xka_pkg::LEVEL_NEG : xka_pkg::LEVEL_POS;
        mark_neg = ~mark_neg;
      end
      s.byte_done    = (k == 0);
      s.message_done = (k == 0) && b.message_end;
      symbols_due.push_back(s);
    end
    // End of message: the next byte starts fresh even without a start flag
    if (b.message_end) begin
      key_pos  = '0;
      mark_neg = 1'b0;
    end
  endfunction

  // Byte driver: predict on acceptance, then offer the next beat or idle.
  // Valid only drops after an accept, and the payload holds while stalled.
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        encode_byte(byte_data);
      end
      if (!byte_valid || byte_ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
          byte_data  <= byte_backlog.pop_front();
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Symbol receiver: random ready, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      sym_ready <= 1'b0;
      hold_left = 0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      sym_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      sym_ready <= 1'b0;
    end else begin
      sym_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Symbol monitor: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin : check_symbols
    xka_pkg::sym_beat_t want;
    if (!rst && sym_valid && sym_ready) begin
      if (symbols_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected symbol, expected none, got level %0d byte_done %0b %s %0b",
                 $time, sym_data.level, sym_data.byte_done, "message_done",
                 sym_data.message_done);
      end else begin
        want = symbols_due.pop_front();
        if (sym_data.level !== want.level || sym_data.byte_done !== want.byte_done ||
            sym_data.message_done !== want.message_done) begin
          mismatch_count++;
          $display("%0t: symbol mismatch, expected level %0d byte_done %0b message_done %0b",
                   $time, want.level, want.byte_done, want.message_done);
          $display("%0t: got level %0d byte_done %0b message_done %0b",
                   $time, sym_data.level, sym_data.byte_done, sym_data.message_done);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One register write; the block is idle, so update the predictor copy at once.
  task automatic cfg_write(input logic [xka_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      xka_pkg::CFG_KEY_WORD0:  key_words[0] = value;
      xka_pkg::CFG_KEY_WORD1:  key_words[1] = value;
      xka_pkg::CFG_KEY_WORD2:  key_words[2] = value;
      xka_pkg::CFG_KEY_WORD3:  key_words[3] = value;
      xka_pkg::CFG_KEY_LENGTH: key_len_reg = value[xka_pkg::KEY_LEN_W-1:0];
      default: ;  // unused index: the block must drop it
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Load the whole key, junk in the unused length bits, then a write to a dead index.
  task automatic program_key(input logic [31:0] w0, input logic [31:0] w1,
                             input logic [31:0] w2, input logic [31:0] w3,
                             input logic [xka_pkg::KEY_LEN_W-1:0] len);
    cfg_write(xka_pkg::CFG_KEY_WORD0, w0);
    cfg_write(xka_pkg::CFG_KEY_WORD1, w1);
    cfg_write(xka_pkg::CFG_KEY_WORD2, w2);
    cfg_write(xka_pkg::CFG_KEY_WORD3, w3);
    cfg_write(xka_pkg::CFG_KEY_LENGTH, ($urandom & ~32'h1F) | 32'(len));
    cfg_write(xka_pkg::CFG_IDX_W'($urandom_range(int'(xka_pkg::CFG_KEY_LENGTH) + 1,
                                                 int'(CFG_IDX_TOP))),
              $urandom);
  endtask

  task automatic add_beat(input logic [7:0] data, input logic first, input logic last);
    xka_pkg::byte_beat_t b;
    b.data_byte     = data;
    b.message_start = first;
    b.message_end   = last;
    byte_backlog.push_back(b);
  endtask

  // A framed message has start on its first beat and end on its last;
  // an unframed one carries random flags.
  task automatic queue_message(input int beats, input bit framed);
    for (int i = 0; i < beats; i++) begin
      add_beat(8'($urandom), framed ? (i == 0) : 1'($urandom),
               framed ? (i == beats - 1) : 1'($urandom));
    end
  endtask

  // Mostly framed messages of random length, the rest noise.
  task automatic queue_traffic(input int target);
    int queued;
    int len;
    queued = 0;
    while (queued < target) begin
      len = $urandom_range(1, 16);
      queue_message(len, $urandom_range(99) < 80);
      queued += len;
    end
  endtask

  // Sender pause: wait at a falling edge until every beat is out and every symbol seen.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (byte_backlog.size() != 0 || byte_valid || symbols_due.size() != 0);
  endtask

  initial begin
    key_words[0] = xka_pkg::KEY_WORD0_RST;
    key_words[1] = xka_pkg::KEY_WORD1_RST;
    key_words[2] = xka_pkg::KEY_WORD2_RST;
    key_words[3] = xka_pkg::KEY_WORD3_RST;
    key_len_reg  = xka_pkg::KEY_LENGTH_RST;
    key_pos      = '0;
    mark_neg     = 1'b0;
    send_idle    = 35;
    recv_idle    = 80;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, default key: first key byte is 0x42, so 0x42 enciphers to all
    // marks and 0xBD to all spaces; plaintext extremes too.
    add_beat(8'h42, 1'b1, 1'b1);
    add_beat(8'hBD, 1'b1, 1'b1);
    add_beat(8'h00, 1'b1, 1'b1);
    add_beat(8'hFF, 1'b1, 1'b1);
    // Twelve bytes: key position wraps past the tenth
    for (int i = 0; i < 12; i++) begin
      add_beat(i[0] ? 8'hFF : 8'h00, i == 0, i == 11);
    end
    // Message with no start flag after an end, then a restart mid-message
    add_beat(8'h5A, 1'b0, 1'b1);
    add_beat(8'h11, 1'b1, 1'b0);
    add_beat(8'h22, 1'b0, 1'b0);
    add_beat(8'h33, 1'b1, 1'b0);
    add_beat(8'h44, 1'b0, 1'b1);
    hold_requests++;
    wait_drained();

    // Zero length acts as one
    program_key($urandom, $urandom, $urandom, $urandom, 5'd0);
    queue_traffic(20);
    wait_drained();

    // Full 16-byte key with extreme words; leave a message open at position 9
    program_key(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, 5'd16);
    queue_traffic(20);
    for (int i = 0; i < 9; i++) begin
      add_beat(8'($urandom), i == 0, 1'b0);
    end
    wait_drained();

    // Shrink the key under the open message: its position falls back to slot 0
    send_idle = 80;
    recv_idle = 35;
    program_key($urandom, $urandom, $urandom, $urandom, 5'd3);
    for (int i = 0; i < 4; i++) begin
      add_beat(8'($urandom), 1'b0, i == 3);
    end
    queue_traffic(20);
    wait_drained();

    // Oversized length clamps to sixteen
    program_key($urandom, $urandom, $urandom, $urandom, 5'd31);
    queue_traffic(20);
    wait_drained();

    // No idling, plus a long hold-off while the sender keeps pushing
    send_idle = 0;
    recv_idle = 0;
    program_key($urandom, $urandom, $urandom, $urandom, 5'd17);
    queue_traffic(20);
    hold_requests++;
    wait_drained();

    // Single-byte key
    program_key($urandom, $urandom, $urandom, $urandom, 5'd1);
    queue_traffic(20);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
